// ===== rtl/sfcb_pkg.sv =====
// ----------------------------------------------------------------------------
// sfcb_pkg
// Shared types and fixed constants of the stereo feedback comb bank.
// ----------------------------------------------------------------------------
package sfcb_pkg;

    localparam int SAMPLE_BITS = 16;
    localparam int COEF_BITS   = 12;
    localparam int DC_BITS     = 24;
    localparam int SUM_W       = 33;   // holds up to 16 combs of gain*sample
    localparam int LEN_BITS    = 14;

    // comb word layout
    localparam int LEN_L_LSB = 0;
    localparam int LEN_R_LSB = 14;
    localparam int FB_L_LSB  = 28;
    localparam int FB_R_LSB  = 40;
    localparam int GAIN_LSB  = 52;

    localparam logic signed [17:0] DC_POLE = 18'sd65208;

    // register indexes
    localparam int REG_MIX   = 0;
    localparam int REG_NORM  = 1;
    localparam int REG_COMB0 = 2;

    localparam logic [15:0] MIX_RESET  = 16'd32768;
    localparam logic [15:0] NORM_RESET = 16'd32768;
    localparam logic [15:0] NORM_MAX   = 16'd32768;

    typedef enum logic [2:0] {
        PO_NONE = 3'd0,
        PO_X    = 3'd1,
        PO_Y    = 3'd2,
        PO_W    = 3'd3,
        PO_M    = 3'd4,
        PO_O    = 3'd5
    } post_op_t;

    typedef struct packed {
        logic     load_in;
        logic     rd;
        logic     calc;
        logic     clear_we;
        logic     load_out;
        post_op_t post;
        logic     ch;
    } sfcb_cmd_t;

endpackage

// ===== rtl/sfcb_in_if.sv =====
// ----------------------------------------------------------------------------
// sfcb_in_if
// Input stream channel: one stereo sample per transfer.
// ----------------------------------------------------------------------------
interface sfcb_in_if;
    logic              valid;
    logic              ready;
    logic signed [15:0] in_left;
    logic signed [15:0] in_right;

    modport source (output valid, output in_left, output in_right, input ready);
    modport sink   (input valid, input in_left, input in_right, output ready);
endinterface

// ===== rtl/sfcb_out_if.sv =====
// ----------------------------------------------------------------------------
// sfcb_out_if
// Output stream channel: one stereo result per transfer.
// ----------------------------------------------------------------------------
interface sfcb_out_if;
    logic              valid;
    logic              ready;
    logic signed [15:0] out_left;
    logic signed [15:0] out_right;

    modport source (output valid, output out_left, output out_right, input ready);
    modport sink   (input valid, input out_left, input out_right, output ready);
endinterface

// ===== rtl/stereo_feedback_comb_bank.sv =====
// ----------------------------------------------------------------------------
// stereo_feedback_comb_bank
// Stereo bank of parallel feedback combs with DC blocker, scaling and mix.
// ----------------------------------------------------------------------------
//  channel  | dir | transfer
//  in_ch    | in  | one stereo sample (in_left, in_right)
//  out_ch   | out | one stereo result (out_left, out_right)
//  apb      | in  | register writes/reads, 64-bit data, regs at 8*i
//
//  Per sample the combs are walked through the single delay-memory port,
//  one read and one write per comb channel, skipping combs with zero gain;
//  then the shared post chain runs once per channel.
//  Reset: a clearing pass zeroes all 2*NUM_COMBS*MAX_DELAY words of the
//  delay memory (196608 by default); in_ch.ready stays low meanwhile.
//  A finished result sits in an output register; the next sample is taken
//  while it waits, and only the final handoff stalls on out_ch.ready.
module stereo_feedback_comb_bank #(
    parameter int NUM_COMBS = 6,
    parameter int MAX_DELAY = 16384
) (
    input  logic        clk,
    input  logic        rst_n,
    sfcb_in_if.sink     in_ch,
    sfcb_out_if.source  out_ch,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [$clog2(8*(NUM_COMBS+2))-1:0] paddr,
    input  logic [63:0] pwdata,
    output logic [63:0] prdata,
    output logic        pready
);
    import sfcb_pkg::*;

    localparam int AW    = $clog2(8 * (NUM_COMBS + 2));
    localparam int DEPTH = 2 * NUM_COMBS * MAX_DELAY;
    localparam int AAW   = $clog2(DEPTH);
    localparam int JW    = (NUM_COMBS > 1) ? $clog2(NUM_COMBS) : 1;

    logic [15:0]    mix, norm_gain;
    logic [63:0]    comb_word [NUM_COMBS];
    sfcb_cmd_t      cmd;
    logic [JW-1:0]  comb_idx;
    logic           chan;
    logic [AAW-1:0] clr_addr;
    logic           gain_zero;

    sfcb_regs #(.NUM_COMBS(NUM_COMBS), .AW(AW)) u_regs (
        .clk       (clk),
        .rst_n     (rst_n),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready),
        .mix       (mix),
        .norm_gain (norm_gain),
        .comb_word (comb_word)
    );

    // sequencer: walks combs, then the per-channel post steps
    sfcb_ctrl #(.JW(JW), .AAW(AAW), .NUM_COMBS(NUM_COMBS), .DEPTH(DEPTH)) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_ch.valid),
        .in_ready  (in_ch.ready),
        .out_valid (out_ch.valid),
        .out_ready (out_ch.ready),
        .gain_zero (gain_zero),
        .cmd       (cmd),
        .comb_idx  (comb_idx),
        .chan      (chan),
        .clr_addr  (clr_addr)
    );

    sfcb_dp #(
        .NUM_COMBS (NUM_COMBS),
        .MAX_DELAY (MAX_DELAY),
        .JW        (JW),
        .AAW       (AAW),
        .DEPTH     (DEPTH)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .comb_idx  (comb_idx),
        .chan      (chan),
        .clr_addr  (clr_addr),
        .in_left   (in_ch.in_left),
        .in_right  (in_ch.in_right),
        .mix       (mix),
        .norm_gain (norm_gain),
        .comb_word (comb_word),
        .gain_zero (gain_zero),
        .out_left  (out_ch.out_left),
        .out_right (out_ch.out_right)
    );
endmodule

// ===== rtl/sfcb_regs.sv =====
// ----------------------------------------------------------------------------
// sfcb_regs
// APB register file: mix, norm_gain and one 64-bit word per comb.
// ----------------------------------------------------------------------------
module sfcb_regs #(
    parameter int NUM_COMBS = 6,
    parameter int AW        = 6
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          psel,
    input  logic          penable,
    input  logic          pwrite,
    input  logic [AW-1:0] paddr,
    input  logic [63:0]   pwdata,
    output logic [63:0]   prdata,
    output logic          pready,
    output logic [15:0]   mix,
    output logic [15:0]   norm_gain,
    output logic [63:0]   comb_word [NUM_COMBS]
);
    import sfcb_pkg::*;

    localparam int IW = AW - 3;

    logic [IW-1:0] idx;
    logic          wr;
    logic [15:0]   mix_reg;
    logic [15:0]   norm_reg;
    logic [63:0]   comb_reg [NUM_COMBS];

    assign idx    = paddr[AW-1:3];
    assign wr     = psel && penable && pwrite;
    assign pready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mix_reg  <= MIX_RESET;
            norm_reg <= NORM_RESET;
            for (int j = 0; j < NUM_COMBS; j++)
            begin
                comb_reg[j] <= '0;
            end
        end
        else if (wr)
        begin
            if (idx == IW'(REG_MIX))
            begin
                mix_reg <= pwdata[15:0];
            end
            else if (idx == IW'(REG_NORM))
            begin
                norm_reg <= pwdata[15:0];
            end
            for (int j = 0; j < NUM_COMBS; j++)
            begin
                if (idx == IW'(REG_COMB0 + j))
                begin
                    comb_reg[j] <= pwdata;
                end
            end
        end
    end

    always_comb
    begin
        prdata = '0;
        if (idx == IW'(REG_MIX))
        begin
            prdata = {48'd0, mix_reg};
        end
        else if (idx == IW'(REG_NORM))
        begin
            prdata = {48'd0, norm_reg};
        end
        for (int j = 0; j < NUM_COMBS; j++)
        begin
            if (idx == IW'(REG_COMB0 + j))
            begin
                prdata = comb_reg[j];
            end
        end
    end

    assign mix       = mix_reg;
    assign norm_gain = norm_reg;
    assign comb_word = comb_reg;
endmodule

// ===== rtl/sfcb_ctrl.sv =====
// ----------------------------------------------------------------------------
// sfcb_ctrl
// Sequencer: clearing pass, comb visits, post chain and output handoff.
// ----------------------------------------------------------------------------
module sfcb_ctrl #(
    parameter int JW  = 3,
    parameter int AAW = 18,
    parameter int NUM_COMBS = 6,
    parameter int DEPTH = 196608
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           in_valid,
    output logic           in_ready,
    output logic           out_valid,
    input  logic           out_ready,
    input  logic           gain_zero,
    output sfcb_pkg::sfcb_cmd_t cmd,
    output logic [JW-1:0]  comb_idx,
    output logic           chan,
    output logic [AAW-1:0] clr_addr
);
    import sfcb_pkg::*;

    typedef enum logic [5:0] {
        ST_CLEAR = 6'b000001,
        ST_IDLE  = 6'b000010,
        ST_READ  = 6'b000100,
        ST_CALC  = 6'b001000,
        ST_POST  = 6'b010000,
        ST_OUT   = 6'b100000
    } state_t;

    state_t         state_reg, state_next;
    logic [JW-1:0]  j_reg, j_next;
    logic           c_reg, c_next;
    logic [AAW-1:0] clr_reg, clr_next;
    post_op_t       op_reg, op_next;
    logic           ch_reg, ch_next;
    logic           ov_reg, ov_next;
    logic           last_comb;

    assign last_comb = (j_reg == JW'(NUM_COMBS - 1));

    always_comb
    begin
        state_next = state_reg;
        j_next     = j_reg;
        c_next     = c_reg;
        clr_next   = clr_reg;
        op_next    = op_reg;
        ch_next    = ch_reg;
        ov_next    = ov_reg;
        cmd        = '0;
        cmd.post   = PO_NONE;
        cmd.ch     = ch_reg;
        if (ov_reg && out_ready)
        begin
            ov_next = 1'b0;
        end
        unique case (state_reg)
            ST_CLEAR:
            begin
                cmd.clear_we = 1'b1;
                clr_next     = clr_reg + 1'b1;
                if (clr_reg == AAW'(DEPTH - 1))
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load_in = 1'b1;
                    j_next      = '0;
                    c_next      = 1'b0;
                    state_next  = ST_READ;
                end
            end
            ST_READ:
            begin
                if (gain_zero)
                begin
                    c_next = 1'b0;
                    if (last_comb)
                    begin
                        op_next    = PO_X;
                        ch_next    = 1'b0;
                        state_next = ST_POST;
                    end
                    else
                    begin
                        j_next = j_reg + 1'b1;
                    end
                end
                else
                begin
                    cmd.rd     = 1'b1;
                    state_next = ST_CALC;
                end
            end
            ST_CALC:
            begin
                cmd.calc   = 1'b1;
                state_next = ST_READ;
                if (!c_reg)
                begin
                    c_next = 1'b1;
                end
                else
                begin
                    c_next = 1'b0;
                    if (last_comb)
                    begin
                        op_next    = PO_X;
                        ch_next    = 1'b0;
                        state_next = ST_POST;
                    end
                    else
                    begin
                        j_next = j_reg + 1'b1;
                    end
                end
            end
            ST_POST:
            begin
                cmd.post = op_reg;
                unique case (op_reg)
                    PO_X:    op_next = PO_Y;
                    PO_Y:    op_next = PO_W;
                    PO_W:    op_next = PO_M;
                    PO_M:    op_next = PO_O;
                    default:
                    begin
                        op_next = PO_X;
                        if (ch_reg)
                        begin
                            state_next = ST_OUT;
                        end
                        else
                        begin
                            ch_next = 1'b1;
                        end
                    end
                endcase
            end
            ST_OUT:
            begin
                if (!ov_reg || out_ready)
                begin
                    cmd.load_out = 1'b1;
                    ov_next      = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CLEAR;
            j_reg     <= '0;
            c_reg     <= 1'b0;
            clr_reg   <= '0;
            op_reg    <= PO_X;
            ch_reg    <= 1'b0;
            ov_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            j_reg     <= j_next;
            c_reg     <= c_next;
            clr_reg   <= clr_next;
            op_reg    <= op_next;
            ch_reg    <= ch_next;
            ov_reg    <= ov_next;
        end
    end

    assign in_ready  = (state_reg == ST_IDLE);
    assign out_valid = ov_reg;
    assign comb_idx  = j_reg;
    assign chan      = c_reg;
    assign clr_addr  = clr_reg;
endmodule

// ===== rtl/sfcb_dp.sv =====
// ----------------------------------------------------------------------------
// sfcb_dp
// Datapath: delay memory, write heads, comb MAC, DC blocker, scale and mix.
// ----------------------------------------------------------------------------
module sfcb_dp #(
    parameter int NUM_COMBS = 6,
    parameter int MAX_DELAY = 16384,
    parameter int JW  = 3,
    parameter int AAW = 18,
    parameter int DEPTH = 196608
) (
    input  logic                clk,
    input  logic                rst_n,
    input  sfcb_pkg::sfcb_cmd_t cmd,
    input  logic [JW-1:0]       comb_idx,
    input  logic                chan,
    input  logic [AAW-1:0]      clr_addr,
    input  logic signed [15:0]  in_left,
    input  logic signed [15:0]  in_right,
    input  logic [15:0]         mix,
    input  logic [15:0]         norm_gain,
    input  logic [63:0]         comb_word [NUM_COMBS],
    output logic                gain_zero,
    output logic signed [15:0]  out_left,
    output logic signed [15:0]  out_right
);
    import sfcb_pkg::*;

    localparam int LINES = 2 * NUM_COMBS;
    localparam int HW    = $clog2(MAX_DELAY);
    localparam logic [16:0] LEN_MAX = 17'(MAX_DELAY - 1);

    logic signed [SAMPLE_BITS-1:0] mem [DEPTH];
    logic signed [SAMPLE_BITS-1:0] rd_q_reg;
    logic [HW-1:0]                 heads_reg [LINES];
    logic signed [15:0]            dry_reg [2];
    logic signed [SUM_W-1:0]       sum_reg [2];
    logic signed [DC_BITS-1:0]     xm1_reg [2];
    logic signed [DC_BITS-1:0]     ym1_reg [2];
    logic signed [DC_BITS-1:0]     x_reg;
    logic signed [41:0]            pole_reg;
    logic signed [41:0]            wm_reg;
    logic signed [34:0]            mp_reg;
    logic signed [15:0]            res_reg [2];
    logic signed [15:0]            ol_reg, or_reg;

    // comb select
    logic [63:0]          w;
    logic [11:0]          gain_f, fb_f;
    logic [LEN_BITS-1:0]  len_f;
    logic [HW-1:0]        len_c, h, h_adv;
    logic [HW:0]          h_inc;
    logic [$clog2(LINES)-1:0] line;
    logic [AAW-1:0]       addr;

    assign line   = {comb_idx, chan};
    assign w      = comb_word[comb_idx];
    assign gain_f = w[GAIN_LSB +: 12];
    assign fb_f   = chan ? w[FB_R_LSB +: 12] : w[FB_L_LSB +: 12];
    assign len_f  = chan ? w[LEN_R_LSB +: LEN_BITS] : w[LEN_L_LSB +: LEN_BITS];
    assign len_c  = (17'(len_f) > LEN_MAX) ? HW'(LEN_MAX) : HW'(len_f);
    assign h      = heads_reg[line];
    assign h_inc  = {1'b0, h} + 1'b1;
    assign h_adv  = (h_inc > {1'b0, len_c}) ? '0 : h_inc[HW-1:0];
    assign addr   = AAW'(line) * AAW'(MAX_DELAY) + AAW'(h);
    assign gain_zero = (gain_f == '0);

    // comb update
    logic signed [28:0] fb_prod, fb_rnd, gain_prod;
    logic signed [16:0] fb_term;
    logic signed [17:0] nv;
    logic signed [15:0] nv_sat, dry_c;

    assign dry_c = dry_reg[chan];

    always_comb
    begin
        fb_prod   = $signed({1'b0, fb_f}) * rd_q_reg;
        gain_prod = $signed({1'b0, gain_f}) * rd_q_reg;
        fb_rnd    = fb_prod + 29'sd2048;
        fb_term   = $signed(fb_rnd[28:COEF_BITS]);
        nv        = 18'(dry_c) + 18'(fb_term);
        if (nv > 18'sd32767)
        begin
            nv_sat = 16'sd32767;
        end
        else if (nv < -18'sd32768)
        begin
            nv_sat = -16'sd32768;
        end
        else
        begin
            nv_sat = nv[15:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.clear_we)
        begin
            mem[clr_addr] <= '0;
        end
        else if (cmd.calc)
        begin
            mem[addr] <= nv_sat;
        end
        if (cmd.rd)
        begin
            rd_q_reg <= mem[addr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < LINES; i++)
            begin
                heads_reg[i] <= '0;
            end
        end
        else if (cmd.calc)
        begin
            heads_reg[line] <= h_adv;
        end
    end

    // post chain
    logic               pc;
    logic signed [24:0] sum_sh;
    logic signed [23:0] x_sat, y_sat;
    logic signed [41:0] pole_rnd, wm_rnd;
    logic signed [25:0] pole_term;
    logic signed [26:0] ysum;
    logic [16:0]        ng;
    logic signed [22:0] wt;
    logic signed [16:0] wet;
    logic signed [17:0] diff;
    logic signed [34:0] mp_rnd;
    logic signed [18:0] mt;
    logic signed [15:0] o_mix;

    assign pc = cmd.ch;

    always_comb
    begin
        sum_sh = $signed(sum_reg[pc][SUM_W-1:COEF_BITS-4]);
        if (sum_sh > 25'sd8388607)
        begin
            x_sat = 24'sd8388607;
        end
        else if (sum_sh < -25'sd8388608)
        begin
            x_sat = -24'sd8388608;
        end
        else
        begin
            x_sat = sum_sh[23:0];
        end
        pole_rnd  = pole_reg + 42'sd32768;
        pole_term = $signed(pole_rnd[41:16]);
        ysum      = 27'(x_reg) - 27'(xm1_reg[pc]) + 27'(pole_term);
        if (ysum > 27'sd8388607)
        begin
            y_sat = 24'sd8388607;
        end
        else if (ysum < -27'sd8388608)
        begin
            y_sat = -24'sd8388608;
        end
        else
        begin
            y_sat = ysum[23:0];
        end
        ng     = (norm_gain > NORM_MAX) ? 17'(NORM_MAX) : {1'b0, norm_gain};
        wm_rnd = wm_reg + 42'sd262144;
        wt     = $signed(wm_rnd[41:19]);
        if (wt > 23'sd32767)
        begin
            wet = 17'sd32767;
        end
        else if (wt < -23'sd32767)
        begin
            wet = -17'sd32767;
        end
        else
        begin
            wet = wt[16:0];
        end
        diff   = 18'(wet) - 18'(dry_reg[pc]);
        mp_rnd = mp_reg + 35'sd32768;
        mt     = $signed(mp_rnd[34:16]);
        o_mix  = dry_reg[pc] + mt[15:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < 2; i++)
            begin
                xm1_reg[i] <= '0;
                ym1_reg[i] <= '0;
            end
        end
        else if (cmd.post == PO_Y)
        begin
            xm1_reg[pc] <= x_reg;
            ym1_reg[pc] <= y_sat;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_in)
        begin
            dry_reg[0] <= in_left;
            dry_reg[1] <= in_right;
            sum_reg[0] <= '0;
            sum_reg[1] <= '0;
        end
        else if (cmd.calc)
        begin
            sum_reg[chan] <= sum_reg[chan] + SUM_W'(gain_prod);
        end
        case (cmd.post)
            PO_X:
            begin
                x_reg    <= x_sat;
                pole_reg <= DC_POLE * ym1_reg[pc];
            end
            PO_W:    wm_reg <= ym1_reg[pc] * $signed({1'b0, ng});
            PO_M:    mp_reg <= $signed({1'b0, mix}) * diff;
            PO_O:    res_reg[pc] <= o_mix;
            default: ;
        endcase
        if (cmd.load_out)
        begin
            ol_reg <= res_reg[0];
            or_reg <= res_reg[1];
        end
    end

    assign out_left  = ol_reg;
    assign out_right = or_reg;
endmodule
